// ===== rtl/u8pt_pkg.sv =====
// u8pt_pkg: shared types, constants and decode functions for the UTF-8
// punctuation transliterator.
// No dependencies.
package u8pt_pkg;

    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_QUEST    = 8'h3F;
    localparam logic [7:0] BYTE_APOS     = 8'h27;
    localparam logic [7:0] BYTE_DQUOTE   = 8'h22;
    localparam logic [7:0] BYTE_HYPHEN   = 8'h2D;
    localparam logic [7:0] BYTE_DOT      = 8'h2E;
    localparam logic [5:0] CONT_PAYLOAD  = 6'h3F;

    // byte classes seen by the front end
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } cls_t;

    // one decoded input: up to four output words
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            eot;
    } job_t;

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        if (b[7] == 1'b0) begin
            c = CLS_ASCII;
        end else if (b[7:6] == 2'b10) begin
            c = CLS_CONT;
        end else if (b[7:5] == 3'b110) begin
            c = CLS_LEAD2;
        end else if (b[7:4] == 4'b1110) begin
            c = CLS_LEAD3;
        end else if (b[7:3] == 5'b11110) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_BAD;
        end
        return c;
    endfunction

    function automatic logic [3:0][7:0] replacement(input logic [20:0] code);
        logic [3:0][7:0] r;
        r = {BYTE_SPACE, BYTE_SPACE, BYTE_SPACE, BYTE_QUEST};
        case (code)
            21'h02018, 21'h02019, 21'h0201A, 21'h02032: r[0] = BYTE_APOS;
            21'h0201C, 21'h0201D, 21'h0201E, 21'h02033: r[0] = BYTE_DQUOTE;
            21'h02013: r[0] = BYTE_HYPHEN;
            21'h02014: begin
                r[0] = BYTE_HYPHEN;
                r[1] = BYTE_HYPHEN;
            end
            21'h02026: begin
                r[0] = BYTE_DOT;
                r[1] = BYTE_DOT;
                r[2] = BYTE_DOT;
            end
            21'h000A0: r[0] = BYTE_SPACE;
            default: r[0] = BYTE_QUEST;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/u8pt_front.sv =====
// u8pt_front: accepts input words, tracks the held UTF-8 sequence and
// turns each input into a job of up to four output bytes.
// Depends on u8pt_pkg.
module u8pt_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] in_byte
    input  logic           s_tlast,   // end_of_text
    input  logic           q_full,
    output logic           push,
    output u8pt_pkg::job_t job,
    output logic           idle
);

    logic [1:0]      pcnt_reg, pcnt_next;
    logic [2:0]      exp_reg, exp_next;
    logic [20:0]     acc_reg, acc_next;
    logic            accept;
    logic            pending;
    u8pt_pkg::cls_t  cls;
    logic [2:0]      cnt_inc;
    logic [20:0]     acc_shift;
    logic [1:0]      flush_n;
    logic [7:0]      fresh_byte;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && !q_full;
    assign pending   = (pcnt_reg != 2'd0);
    assign idle      = !pending;
    assign cls       = u8pt_pkg::classify(s_tdata);
    assign cnt_inc   = {1'b0, pcnt_reg} + 3'd1;
    assign acc_shift = {acc_reg[14:0], s_tdata[5:0] & u8pt_pkg::CONT_PAYLOAD};
    assign flush_n   = pending ? pcnt_reg : 2'd0;
    assign fresh_byte = (cls == u8pt_pkg::CLS_ASCII) ? s_tdata : u8pt_pkg::BYTE_SPACE;

    always_comb begin
        pcnt_next = pcnt_reg;
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        job.bytes = {4{u8pt_pkg::BYTE_SPACE}};
        job.count = 3'd0;
        job.eot   = s_tlast;
        if (pending && cls == u8pt_pkg::CLS_CONT) begin
            if (cnt_inc >= exp_reg) begin
                job.bytes = u8pt_pkg::replacement(acc_shift);
                job.count = exp_reg;
                pcnt_next = 2'd0;
                exp_next  = 3'd0;
                acc_next  = 21'd0;
            end else if (s_tlast) begin
                job.count = cnt_inc;
                pcnt_next = 2'd0;
                exp_next  = 3'd0;
                acc_next  = 21'd0;
            end else begin
                pcnt_next = cnt_inc[1:0];
                acc_next  = acc_shift;
            end
        end else begin
            case (cls)
                u8pt_pkg::CLS_LEAD2, u8pt_pkg::CLS_LEAD3, u8pt_pkg::CLS_LEAD4: begin
                    if (s_tlast) begin
                        job.count = {1'b0, flush_n} + 3'd1;
                        pcnt_next = 2'd0;
                        exp_next  = 3'd0;
                        acc_next  = 21'd0;
                    end else begin
                        job.count = {1'b0, flush_n};
                        pcnt_next = 2'd1;
                        case (cls)
                            u8pt_pkg::CLS_LEAD2: begin
                                exp_next = 3'd2;
                                acc_next = {16'd0, s_tdata[4:0]};
                            end
                            u8pt_pkg::CLS_LEAD3: begin
                                exp_next = 3'd3;
                                acc_next = {17'd0, s_tdata[3:0]};
                            end
                            default: begin
                                exp_next = 3'd4;
                                acc_next = {18'd0, s_tdata[2:0]};
                            end
                        endcase
                    end
                end
                default: begin
                    for (int i = 0; i < 4; i++) begin
                        if (flush_n == i[1:0]) begin
                            job.bytes[i] = fresh_byte;
                        end
                    end
                    job.count = {1'b0, flush_n} + 3'd1;
                    pcnt_next = 2'd0;
                    exp_next  = 3'd0;
                    acc_next  = 21'd0;
                end
            endcase
        end
    end

    assign push = accept && (job.count != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg <= 2'd0;
            exp_reg  <= 3'd0;
            acc_reg  <= 21'd0;
        end else if (accept) begin
            pcnt_reg <= pcnt_next;
            exp_reg  <= exp_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

// ===== rtl/u8pt_queue.sv =====
// u8pt_queue: short job queue between front and back ends.
// Depends on u8pt_pkg.
module u8pt_queue #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  u8pt_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output u8pt_pkg::job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u8pt_pkg::job_t    mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/u8pt_back.sv =====
// u8pt_back: unpacks queued jobs into single output words through an
// output register.
// Depends on u8pt_pkg.
module u8pt_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  u8pt_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // [7:0] out_byte
    output logic           m_tlast,   // run_last
    output logic           m_tuser    // text_last
);

    logic [1:0] idx_reg, idx_next;
    logic       vld_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       user_reg;
    logic       load;
    logic       is_last;

    assign load    = !empty && (!vld_reg || m_tready);
    assign is_last = ({1'b0, idx_reg} + 3'd1) == head.count;
    assign pop     = load && is_last;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                vld_reg <= 1'b1;
            end else if (m_tready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= head.bytes[idx_reg];
            last_reg <= is_last;
            user_reg <= is_last && head.eot;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

// ===== rtl/utf8_punctuation_transliterator.sv =====
// utf8_punctuation_transliterator: top level of the UTF-8 to ASCII
// punctuation filter; front end, job queue and back end.
// Depends on u8pt_pkg, u8pt_front, u8pt_queue, u8pt_back.
//
//  channel | dir | tdata         | tlast       | tuser
//  s_      | in  | [7:0] in_byte | end_of_text | -
//  m_      | out | [7:0] out_byte| run_last    | text_last
//
// One input word is taken per cycle while the job queue has room; output
// words leave one per cycle while m_tready is high, so a replacement of n
// bytes leaves as n words at the back end. An accepted word's job passes
// through the queue, then the output register. Reset clears the held
// sequence and empties the queue. An m_ stall backs up into the queue and
// then holds s_tready low.
module utf8_punctuation_transliterator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // text_last
);

    u8pt_pkg::job_t push_job;
    u8pt_pkg::job_t head;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    logic           front_idle;

    u8pt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .job      (push_job),
        .idle     (front_idle)
    );

    u8pt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    u8pt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_text_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("text_last without run_last");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("job pushed into full queue");

    a_eot_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> front_idle)
        else $error("sequence still held after end of text");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_empty && head.count != 3'd0)
        else $error("pop from empty queue or empty job");

endmodule

// ===== test/utf8_punctuation_transliterator_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for utf8_punctuation_transliterator: directed and random UTF-8
// text with random idling, checked word by word against a built-in transliterator.
// Depends on u8pt_pkg and the RTL of utf8_punctuation_transliterator.
module utf8_punctuation_transliterator_test;

    localparam logic [20:0] CP_LSQUO  = 21'h02018;
    localparam logic [20:0] CP_RSQUO  = 21'h02019;
    localparam logic [20:0] CP_SBQUO  = 21'h0201A;
    localparam logic [20:0] CP_PRIME  = 21'h02032;
    localparam logic [20:0] CP_LDQUO  = 21'h0201C;
    localparam logic [20:0] CP_RDQUO  = 21'h0201D;
    localparam logic [20:0] CP_BDQUO  = 21'h0201E;
    localparam logic [20:0] CP_DPRIME = 21'h02033;
    localparam logic [20:0] CP_NDASH  = 21'h02013;
    localparam logic [20:0] CP_MDASH  = 21'h02014;
    localparam logic [20:0] CP_HELLIP = 21'h02026;
    localparam logic [20:0] CP_NBSP   = 21'h000A0;

    localparam int HOLD_CYCLES    = 120;
    localparam int STALL_LIMIT    = 1000;
    localparam int TAIL_CYCLES    = 12;
    localparam int PRINT_LIMIT    = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_last;
    } out_word_t;

    class translit_checker;
        out_word_t   owed_words[$];
        int unsigned errors;
        int unsigned held;
        int unsigned seq_len;
        logic [20:0] code_acc;
        logic [7:0]  run_q[$];

        function u8pt_pkg::cls_t byte_class(logic [7:0] b);
            u8pt_pkg::cls_t c;
            casez (b)
                8'b0???????: c = u8pt_pkg::CLS_ASCII;
                8'b10??????: c = u8pt_pkg::CLS_CONT;
                8'b110?????: c = u8pt_pkg::CLS_LEAD2;
                8'b1110????: c = u8pt_pkg::CLS_LEAD3;
                8'b11110???: c = u8pt_pkg::CLS_LEAD4;
                default:     c = u8pt_pkg::CLS_BAD;
            endcase
            return c;
        endfunction

        function void clear_seq();
            held     = 0;
            seq_len  = 0;
            code_acc = '0;
        endfunction

        function void flush_held();
            for (int k = 0; k < held; k++) run_q = {run_q, u8pt_pkg::BYTE_SPACE};
            clear_seq();
        endfunction

        function void close_seq();
            logic [7:0] rep [4];
            rep = '{u8pt_pkg::BYTE_QUEST, u8pt_pkg::BYTE_SPACE, u8pt_pkg::BYTE_SPACE,
                    u8pt_pkg::BYTE_SPACE};
            case (code_acc)
                CP_LSQUO, CP_RSQUO, CP_SBQUO, CP_PRIME: rep[0] = u8pt_pkg::BYTE_APOS;
                CP_LDQUO, CP_RDQUO, CP_BDQUO, CP_DPRIME: rep[0] = u8pt_pkg::BYTE_DQUOTE;
                CP_NDASH: rep[0] = u8pt_pkg::BYTE_HYPHEN;
                CP_MDASH: begin
                    rep[0] = u8pt_pkg::BYTE_HYPHEN;
                    rep[1] = u8pt_pkg::BYTE_HYPHEN;
                end
                CP_HELLIP: begin
                    rep[0] = u8pt_pkg::BYTE_DOT;
                    rep[1] = u8pt_pkg::BYTE_DOT;
                    rep[2] = u8pt_pkg::BYTE_DOT;
                end
                CP_NBSP: rep[0] = u8pt_pkg::BYTE_SPACE;
                default: rep[0] = u8pt_pkg::BYTE_QUEST;
            endcase
            for (int k = 0; k < seq_len; k++) run_q = {run_q, rep[k]};
            clear_seq();
        endfunction

        function void take_fresh(logic [7:0] b);
            case (byte_class(b))
                u8pt_pkg::CLS_ASCII: run_q = {run_q, b};
                u8pt_pkg::CLS_LEAD2: begin
                    held = 1; seq_len = 2; code_acc = {16'd0, b[4:0]};
                end
                u8pt_pkg::CLS_LEAD3: begin
                    held = 1; seq_len = 3; code_acc = {17'd0, b[3:0]};
                end
                u8pt_pkg::CLS_LEAD4: begin
                    held = 1; seq_len = 4; code_acc = {18'd0, b[2:0]};
                end
                default: run_q = {run_q, u8pt_pkg::BYTE_SPACE};
            endcase
        endfunction

        function void transliterate(logic [7:0] b, logic eot);
            out_word_t w;
            run_q.delete();
            if (held != 0) begin
                if (byte_class(b) == u8pt_pkg::CLS_CONT) begin
                    code_acc = {code_acc[14:0], b[5:0]};
                    held++;
                    if (held >= seq_len) close_seq();
                end else begin
                    flush_held();
                    take_fresh(b);
                end
            end else begin
                take_fresh(b);
            end
            if (eot && held != 0) flush_held();
            foreach (run_q[k]) begin
                w.data      = run_q[k];
                w.run_last  = (k == run_q.size() - 1);
                w.text_last = eot && (k == run_q.size() - 1);
                owed_words = {owed_words, w};
            end
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("%0t ns mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(logic [7:0] data, logic run_last, logic text_last);
            out_word_t w;
            if (owed_words.size() == 0) begin
                report($sformatf("word %02h with nothing owed", data));
                return;
            end
            w = owed_words.pop_front();
            if (data !== w.data)
                report($sformatf("out_byte %02h, owed %02h", data, w.data));
            if (run_last !== w.run_last)
                report($sformatf("run_last %b, owed %b on byte %02h", run_last, w.run_last,
                                 w.data));
            if (text_last !== w.text_last)
                report($sformatf("text_last %b, owed %b on byte %02h", text_last,
                                 w.text_last, w.data));
        endtask

        function int owed();
            return owed_words.size();
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    translit_checker sb = new;

    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         hold_ticket = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;
    int         quiet_cycles = 0;
    logic [7:0] text_q[$];

    utf8_punctuation_transliterator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_ticket != hold_seen) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_word(input logic [7:0] b, input logic eot);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.transliterate(b, eot);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.owed() != 0) @(posedge aclk);
    endtask

    function automatic logic [20:0] punct_code(int i);
        logic [20:0] cp;
        case (i)
            0:  cp = CP_LSQUO;
            1:  cp = CP_RSQUO;
            2:  cp = CP_SBQUO;
            3:  cp = CP_PRIME;
            4:  cp = CP_LDQUO;
            5:  cp = CP_RDQUO;
            6:  cp = CP_BDQUO;
            7:  cp = CP_DPRIME;
            8:  cp = CP_NDASH;
            9:  cp = CP_MDASH;
            10: cp = CP_HELLIP;
            default: cp = CP_NBSP;
        endcase
        return cp;
    endfunction

    function automatic void push_code(logic [20:0] cp, int len);
        case (len)
            2:       text_q = {text_q, {3'b110, cp[10:6]}};
            3:       text_q = {text_q, {4'b1110, cp[15:12]}};
            default: text_q = {text_q, {5'b11110, cp[20:18]}};
        endcase
        for (int k = len - 2; k >= 0; k--) text_q = {text_q, {2'b10, cp[6 * k +: 6]}};
    endfunction

    task automatic send_random(input int count);
        int          sent;
        int          pick;
        int          len;
        logic [20:0] cp;
        logic [7:0]  b;
        sent = 0;
        while (sent < count) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 35) begin
                b = 8'($urandom_range(0, 127));
                text_q = {text_q, b};
            end else if (pick < 60) begin
                cp = punct_code(int'($urandom_range(0, 11)));
                push_code(cp, (cp == CP_NBSP) ? 2 : 3);
            end else if (pick < 80) begin
                push_code(21'($urandom_range(0, 21'h1FFFFF)), int'($urandom_range(2, 4)));
            end else if (pick < 90) begin
                // cut a sequence short, then break it with a non-continuation byte
                len = int'($urandom_range(2, 4));
                push_code(21'($urandom_range(0, 21'h1FFFFF)), len);
                repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10) b[6] = 1'b1;
                text_q = {text_q, b};
            end else begin
                b = 8'($urandom_range(0, 255));
                text_q = {text_q, b};
            end
            foreach (text_q[k]) send_word(text_q[k], $urandom_range(0, 19) == 0);
            sent += text_q.size();
            text_q.delete();
        end
    endtask

    task automatic run_phase(input int send_idle, input int recv_stall, input int count);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        send_random(count);
        drain();
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        send_word(8'h00, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hE2, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h98, 1'b0);
        send_word(8'hE2, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h94, 1'b0);
        send_word(8'hE2, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hA6, 1'b0);
        send_word(8'hC2, 1'b0);
        send_word(8'hA0, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'h9F, 1'b0);
        send_word(8'h98, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'hE2, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'hC0, 1'b1);
        send_word(8'hC1, 1'b0);
        send_word(8'hBF, 1'b1);
        drain();

        run_phase(0, 0, 65);
        run_phase(48, 0, 65);
        run_phase(0, 48, 65);
        run_phase(37, 37, 65);

        // hold the receiver off while the sender keeps offering words
        stall_pct = 0;
        idle_pct  = 0;
        hold_ticket++;
        send_random(24);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
